/* sv/dbc_pkg.sv */
`default_nettype none
package dbc_pkg;

    localparam int POS_W  = 16;
    localparam int ACC_W  = 15;
    localparam int ID_W   = 8;
    localparam int CL_W   = 12;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_MERGE   = 2'd0;
    localparam logic [1:0] REG_LAT_ACC = 2'd1;
    localparam logic [1:0] REG_FWD_ACC = 2'd2;

    localparam logic             MERGE_RST = 1'b1;
    localparam logic [ACC_W-1:0] ACC_RST   = 15'd100;

    typedef struct packed {
        logic             merge;
        logic [ACC_W-1:0] lat_acc;
        logic [ACC_W-1:0] fwd_acc;
    } t_cfg;

    typedef struct packed {
        logic                    merge;
        logic [ACC_W-1:0]        lat_acc;
        logic [ACC_W-1:0]        fwd_acc;
        logic signed [POS_W-1:0] fwd;
        logic signed [POS_W-1:0] lat;
    } t_query;

    typedef struct packed {
        logic            act;
        logic            found;
        logic [CL_W-1:0] best;
    } t_token;

    typedef struct packed {
        logic                    en;
        logic [CL_W-1:0]         idx;
        logic signed [POS_W-1:0] fwd;
        logic signed [POS_W-1:0] lat;
        logic [CL_W-1:0]         cl;
    } t_wr;

endpackage
`default_nettype wire

/* sv/dbc_ifs.sv */
`default_nettype none
interface dbc_det_if;
    import dbc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    frame_start;
    logic signed [POS_W-1:0] forward_pos;
    logic signed [POS_W-1:0] lateral_pos;
    modport source (output valid, frame_start, forward_pos, lateral_pos, input ready);
    modport sink   (input valid, frame_start, forward_pos, lateral_pos, output ready);
endinterface

interface dbc_clu_if;
    import dbc_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] cluster_id;
    logic            new_cluster;
    logic            store_full;
    modport source (output valid, cluster_id, new_cluster, store_full, input ready);
    modport sink   (input valid, cluster_id, new_cluster, store_full, output ready);
endinterface
`default_nettype wire

/* sv/dbc_cfg.sv */
`default_nettype none
module dbc_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dbc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dbc_pkg::DATA_W-1:0]   pwdata,
    output logic      [dbc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output dbc_pkg::t_cfg                     o_cfg
);
    import dbc_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.merge   <= MERGE_RST;
            r_cfg.lat_acc <= ACC_RST;
            r_cfg.fwd_acc <= ACC_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_MERGE:   r_cfg.merge   <= pwdata[0];
                REG_LAT_ACC: r_cfg.lat_acc <= pwdata[ACC_W-1:0];
                REG_FWD_ACC: r_cfg.fwd_acc <= pwdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MERGE:   prdata = DATA_W'(r_cfg.merge);
            REG_LAT_ACC: prdata = DATA_W'(r_cfg.lat_acc);
            REG_FWD_ACC: prdata = DATA_W'(r_cfg.fwd_acc);
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/dbc_cell.sv */
`default_nettype none
module dbc_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dbc_pkg::t_query i_query,
    input  wire dbc_pkg::t_wr    i_wr,
    input  wire logic            i_kill,
    input  wire dbc_pkg::t_token i_tok,
    output dbc_pkg::t_token      o_tok
);
    import dbc_pkg::*;

    logic signed [POS_W-1:0] r_fwd;
    logic signed [POS_W-1:0] r_lat;
    logic [IDX_W-1:0]        r_cl;
    t_token                  r_tok;
    t_token                  n_tok;

    logic signed [POS_W:0] w_dlat;
    logic signed [POS_W:0] w_dfwd;
    logic signed [POS_W:0] w_wlat;
    logic signed [POS_W:0] w_wfwd;
    logic                  w_hit;
    logic [CL_W-1:0]       w_cl;

    // member store: written when a stored detection takes this slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == CL_W'(INDEX)) begin
            r_fwd <= i_wr.fwd;
            r_lat <= i_wr.lat;
            r_cl  <= i_wr.cl[IDX_W-1:0];
        end
    end

    // strict window test on both axes
    assign w_dlat = {i_query.lat[POS_W-1], i_query.lat} - {r_lat[POS_W-1], r_lat};
    assign w_dfwd = {i_query.fwd[POS_W-1], i_query.fwd} - {r_fwd[POS_W-1], r_fwd};
    assign w_wlat = $signed({2'b00, i_query.lat_acc});
    assign w_wfwd = $signed({2'b00, i_query.fwd_acc});
    assign w_hit  = i_query.merge
                 && (w_dlat < w_wlat) && (w_dlat > -w_wlat)
                 && (w_dfwd < w_wfwd) && (w_dfwd > -w_wfwd);
    assign w_cl   = CL_W'(r_cl);

    always_comb begin
        n_tok       = i_tok;
        n_tok.act   = i_tok.act && !i_kill;
        if (i_tok.act && w_hit) begin
            n_tok.found = 1'b1;
            if (!i_tok.found || w_cl < i_tok.best) begin
                n_tok.best = w_cl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.act <= 1'b0;
        end else begin
            r_tok.act <= n_tok.act;
        end
        r_tok.found <= n_tok.found;
        r_tok.best  <= n_tok.best;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

/* sv/detection_box_clusterer.sv */
// channel | dir | fields                                    | accepted when
// i_det   | in  | frame_start, forward_pos, lateral_pos     | valid && ready
// o_clu   | out | cluster_id, new_cluster, store_full       | valid && ready
// apb     | in  | merge_enable, lateral_accept, forward_... | psel & penable & pwrite
//
// one detection is in flight at a time; a search token walks one member cell per
// cycle down the chain from its input beat to its result; a dropped detection
// (store full) skips the search; reset is synchronous and active low
// members need none; the counts, state, config and output valid are cleared
// a finished result waits in the output register; the next input beat is taken
// meanwhile, and a second result waits in a pending register until the first is taken
`default_nettype none
module detection_box_clusterer #(
    parameter int MAX_DETECTIONS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    dbc_det_if.sink                          i_det,
    dbc_clu_if.source                        o_clu,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dbc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [dbc_pkg::DATA_W-1:0]  pwdata,
    output logic      [dbc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import dbc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);
    localparam int IDX_W = (MAX_DETECTIONS > 2) ? $clog2(MAX_DETECTIONS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;

    t_state                  r_state;
    logic                    r_start;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_ccount;
    logic signed [POS_W-1:0] r_fwd;
    logic signed [POS_W-1:0] r_lat;
    logic [ID_W-1:0]         r_pend_cid;
    logic                    r_pend_new;
    logic                    r_pend_full;
    logic                    r_ovalid;
    logic [ID_W-1:0]         r_ocid;
    logic                    r_onew;
    logic                    r_ofull;

    t_cfg             w_cfg;
    t_query           w_query;
    t_wr              w_wr;
    t_token           w_tok [0:MAX_DETECTIONS];
    t_token           w_tail;
    logic [CNT_W-1:0] w_cnt;
    logic [IDX_W-1:0] w_best;
    logic             w_done;

    // register file
    dbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // query broadcast to every cell
    assign w_query.merge   = w_cfg.merge;
    assign w_query.lat_acc = w_cfg.lat_acc;
    assign w_query.fwd_acc = w_cfg.fwd_acc;
    assign w_query.fwd     = r_fwd;
    assign w_query.lat     = r_lat;

    // token enters the head of the chain in the cycle after the input beat
    assign w_tok[0].act   = r_start;
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].best  = '0;

    for (genvar k = 0; k < MAX_DETECTIONS; k++) begin : g_cell
        dbc_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (w_query),
            .i_wr    (w_wr),
            .i_kill  (w_done),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // the search ends when the token reaches the first free slot
    assign w_tail = w_tok[r_count];
    assign w_done = (r_state == S_RUN) && w_tail.act;

    // lowest matching cluster, or a fresh number
    assign w_best = w_tail.found ? w_tail.best[IDX_W-1:0] : r_ccount[IDX_W-1:0];

    // new member goes into the free slot as the search ends (also kills the token)
    assign w_wr.en  = w_done;
    assign w_wr.idx = CL_W'(r_count[IDX_W-1:0]);
    assign w_wr.fwd = r_fwd;
    assign w_wr.lat = r_lat;
    assign w_wr.cl  = CL_W'(w_best);

    // member count as seen by this beat, after a frame start clears it
    assign w_cnt = i_det.frame_start ? '0 : r_count;

    assign i_det.ready       = (r_state == S_IDLE);
    assign o_clu.valid       = r_ovalid;
    assign o_clu.cluster_id  = r_ocid;
    assign o_clu.new_cluster = r_onew;
    assign o_clu.store_full  = r_ofull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_count  <= '0;
            r_ccount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && o_clu.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_det.valid) begin
                        r_fwd <= i_det.forward_pos;
                        r_lat <= i_det.lateral_pos;
                        if (i_det.frame_start) begin
                            r_count  <= '0;
                            r_ccount <= '0;
                        end
                        if (w_cnt == CNT_W'(MAX_DETECTIONS)) begin
                            // store full: dropped, no search
                            r_pend_cid  <= '0;
                            r_pend_new  <= 1'b0;
                            r_pend_full <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_done) begin
                        r_count <= r_count + 1'b1;
                        if (!w_tail.found) begin
                            r_ccount <= r_ccount + 1'b1;
                        end
                        r_pend_cid  <= ID_W'(w_best);
                        r_pend_new  <= !w_tail.found;
                        r_pend_full <= 1'b0;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_clu.ready) begin
                        r_ovalid <= 1'b1;
                        r_ocid   <= r_pend_cid;
                        r_onew   <= r_pend_new;
                        r_ofull  <= r_pend_full;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/dbc_chk.sv */
`default_nettype none
module dbc_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_cluster_id,
    input wire logic       i_new_cluster,
    input wire logic       i_store_full
);

    // a dropped detection carries no cluster
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_store_full) |-> (i_cluster_id == 8'd0 && !i_new_cluster))
        else $error("store_full beat with cluster fields set");

    // one detection at a time: no input beat right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken twice in a row");

    // a result never appears in the cycle right after its input beat
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result ahead of its search");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_cluster_id) && $stable(i_new_cluster)
             && $stable(i_store_full)))
        else $error("stalled result changed");

endmodule

bind detection_box_clusterer dbc_chk u_dbc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_det.valid),
    .i_in_ready    (i_det.ready),
    .i_out_valid   (o_clu.valid),
    .i_out_ready   (o_clu.ready),
    .i_cluster_id  (o_clu.cluster_id),
    .i_new_cluster (o_clu.new_cluster),
    .i_store_full  (o_clu.store_full)
);
`default_nettype wire

/* tb/detection_box_clusterer_tb.sv */
`default_nettype none
module detection_box_clusterer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbc_pkg::*;

    localparam int MAX_DET     = 256;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_CAP  = 40;
    // one index past the register list, writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    // one result beat as the block should produce it
    typedef struct packed {
        logic [ID_W-1:0] cluster_id;
        logic            new_cluster;
        logic            store_full;
    } t_label;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    dbc_det_if det_if ();
    dbc_clu_if clu_if ();

    detection_box_clusterer #(
        .MAX_DETECTIONS(MAX_DET)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_det   (det_if),
        .o_clu   (clu_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: member store, counts and register values
    logic signed [POS_W-1:0] mem_fwd [MAX_DET];
    logic signed [POS_W-1:0] mem_lat [MAX_DET];
    int                      mem_cluster [MAX_DET];
    int                      det_count;
    int                      clu_count;
    logic                    cfg_merge;
    int                      cfg_lat_acc;
    int                      cfg_fwd_acc;

    // labels still owed by the block, oldest first
    t_label label_queue [$];

    int error_count;
    int cycle_count;
    int detections_sent;
    bit send_gaps;
    bit recv_stalls;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL detection_box_clusterer");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // strict window on one axis: |a - b| < w
    function automatic bit within_accept(input int a, input int b, input int w);
        return (a < b + w) && (a > b - w);
    endfunction

    // greedy clustering of one accepted detection, updates the shadow store
    function automatic t_label cluster_detection(input logic fs,
                                                 input logic signed [POS_W-1:0] fwd,
                                                 input logic signed [POS_W-1:0] lat);
        t_label lab;
        int     best;
        bit     found;
        lab   = '0;
        best  = 0;
        found = 1'b0;
        if (fs) begin
            det_count = 0;
            clu_count = 0;
        end
        // full store drops the detection, nothing is stored or opened
        if (det_count >= MAX_DET) begin
            lab.store_full = 1'b1;
            return lab;
        end
        if (cfg_merge) begin
            for (int i = 0; i < det_count; i++) begin
                if (within_accept(int'(lat), int'(mem_lat[i]), cfg_lat_acc) &&
                    within_accept(int'(fwd), int'(mem_fwd[i]), cfg_fwd_acc)) begin
                    // lowest cluster number wins, not the first member hit
                    if (!found || mem_cluster[i] < best)
                        best = mem_cluster[i];
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            best = clu_count;
            clu_count++;
        end
        mem_fwd[det_count]     = fwd;
        mem_lat[det_count]     = lat;
        mem_cluster[det_count] = best;
        det_count++;
        lab.cluster_id  = best[ID_W-1:0];
        lab.new_cluster = !found;
        return lab;
    endfunction

    // result side: compare every accepted beat with the oldest label
    always @(posedge i_clk) begin : check_result
        t_label want;
        if (i_rst_n && clu_if.valid && clu_if.ready) begin
            if (label_queue.size() == 0) begin
                report_mismatch("result beat with no detection waiting");
            end else begin
                want = label_queue.pop_front();
                if (clu_if.cluster_id !== want.cluster_id)
                    report_mismatch($sformatf("cluster_id got %0d want %0d",
                                              clu_if.cluster_id, want.cluster_id));
                if (clu_if.new_cluster !== want.new_cluster)
                    report_mismatch($sformatf("new_cluster got %b want %b",
                                              clu_if.new_cluster, want.new_cluster));
                if (clu_if.store_full !== want.store_full)
                    report_mismatch($sformatf("store_full got %b want %b",
                                              clu_if.store_full, want.store_full));
            end
        end
    end

    // result side backpressure: random stall bursts when enabled
    initial begin
        clu_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (recv_stalls && $urandom_range(0, 7) == 0) begin
                clu_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            clu_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // one detection beat; returns at the edge that accepted it
    task automatic send_detection(input logic fs,
                                  input logic signed [POS_W-1:0] fwd,
                                  input logic signed [POS_W-1:0] lat);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            // junk on the payload while valid is low
            det_if.valid       <= 1'b0;
            det_if.frame_start <= 1'($urandom);
            det_if.forward_pos <= POS_W'($urandom);
            det_if.lateral_pos <= POS_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        det_if.valid       <= 1'b1;
        det_if.frame_start <= fs;
        det_if.forward_pos <= fwd;
        det_if.lateral_pos <= lat;
        @(posedge i_clk);
        while (!det_if.ready) @(posedge i_clk);
        label_queue.insert(label_queue.size(), cluster_detection(fs, fwd, lat));
        detections_sent++;
    endtask

    // hold off input until every owed label has come back
    task automatic wait_idle();
        det_if.valid <= 1'b0;
        @(posedge i_clk);
        while (label_queue.size() != 0) @(posedge i_clk);
        // every detection yields a result, so an empty queue means nothing is left in flight
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access phase, the register takes it on the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MERGE:   cfg_merge   = data[0];
            REG_LAT_ACC: cfg_lat_acc = int'(data[ACC_W-1:0]);
            REG_FWD_ACC: cfg_fwd_acc = int'(data[ACC_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // all three registers plus the unused slot; upper bits are random junk
    task automatic configure(input logic merge, input int lat_acc, input int fwd_acc);
        logic [DATA_W-1:0] d;
        wait_idle();
        d = $urandom;
        d[0] = merge;
        write_reg(REG_MERGE, d);
        d = $urandom;
        d[ACC_W-1:0] = ACC_W'(lat_acc);
        write_reg(REG_LAT_ACC, d);
        d = $urandom;
        d[ACC_W-1:0] = ACC_W'(fwd_acc);
        write_reg(REG_FWD_ACC, d);
        write_reg(REG_SPARE, $urandom);
    endtask

    function automatic int near_offset(input int acc);
        return int'($urandom_range(0, 2 * acc)) - acc;
    endfunction

    // one frame of detections scattered around a few random centers
    task automatic run_frame(input int count, input logic opens);
        int                      ctr_fwd [4];
        int                      ctr_lat [4];
        int                      n_ctr;
        int                      c;
        int                      pick;
        int                      df;
        int                      dl;
        logic                    fs;
        logic signed [POS_W-1:0] f;
        logic signed [POS_W-1:0] l;
        n_ctr = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++) begin
            ctr_fwd[k] = int'($urandom_range(0, 65535)) - 32768;
            ctr_lat[k] = int'($urandom_range(0, 65535)) - 32768;
        end
        for (int i = 0; i < count; i++) begin
            // a stray frame start inside the frame now and then
            fs   = (i == 0) ? opens : ($urandom_range(0, 49) == 0);
            c    = $urandom_range(0, n_ctr - 1);
            pick = $urandom_range(0, 9);
            df   = near_offset(cfg_fwd_acc);
            dl   = near_offset(cfg_lat_acc);
            if (pick == 1) begin
                // exactly on the bound of one axis
                if ($urandom_range(0, 1) == 1)
                    df = ($urandom_range(0, 1) == 1) ? cfg_fwd_acc : -cfg_fwd_acc;
                else
                    dl = ($urandom_range(0, 1) == 1) ? cfg_lat_acc : -cfg_lat_acc;
            end
            f = POS_W'(ctr_fwd[c] + df);
            l = POS_W'(ctr_lat[c] + dl);
            if (pick == 0) begin
                f = POS_W'($urandom);
                l = POS_W'($urandom);
            end
            send_detection(fs, f, l);
            if ($urandom_range(0, 39) == 0)
                wait_idle();
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset values of the registers: merge on, window of 100 on both axes
    task automatic test_reset_values();
        send_detection(1'b1, 16'sd0, 16'sd0);
        send_detection(1'b0, 16'sd99, -16'sd99);
        send_detection(1'b0, -16'sd100, 16'sd0);
        send_detection(1'b0, 16'sd0, 16'sd100);
        send_detection(1'b0, 16'sh7fff, 16'sh7fff);
        send_detection(1'b0, -16'sh8000, -16'sh8000);
        send_detection(1'b0, 16'sh7fff, -16'sh8000);
        send_detection(1'b0, -16'sh8000, 16'sh7fff);
        send_detection(1'b0, -16'sd1, -16'sd1);
    endtask

    // a detection close to two clusters joins the lower-numbered one
    task automatic test_lowest_cluster();
        send_detection(1'b1, 16'sd500, 16'sd0);
        send_detection(1'b0, 16'sd0, 16'sd0);
        send_detection(1'b0, 16'sd90, 16'sd0);
        send_detection(1'b0, 16'sd420, 16'sd10);
        send_detection(1'b0, 16'sd250, 16'sd0);
        send_detection(1'b0, 16'sd170, 16'sd0);
    endtask

    // merging off: identical detections still open a cluster each
    task automatic test_merge_off();
        configure(1'b0, 100, 100);
        send_detection(1'b1, 16'sd7, 16'sd7);
        send_detection(1'b0, 16'sd7, 16'sd7);
        send_detection(1'b0, 16'sd8, 16'sd7);
    endtask

    // zero window never merges, even on the same spot
    task automatic test_zero_accept();
        configure(1'b1, 0, 0);
        send_detection(1'b1, 16'sd3, -16'sd3);
        send_detection(1'b0, 16'sd3, -16'sd3);
        configure(1'b1, 0, 32767);
        send_detection(1'b0, 16'sd3, -16'sd3);
    endtask

    // widest window: the two ends of the range stay apart
    task automatic test_wide_accept();
        configure(1'b1, 32767, 32767);
        send_detection(1'b1, -16'sh8000, -16'sh8000);
        send_detection(1'b0, 16'sh7fff, 16'sh7fff);
        send_detection(1'b0, -16'sd1, -16'sd1);
        send_detection(1'b0, 16'sd0, 16'sd0);
    endtask

    // fill the store, see drops, then a frame start on the full store
    task automatic test_full_store();
        configure(1'b1, 100, 100);
        for (int i = 0; i < MAX_DET; i++)
            send_detection(i == 0, POS_W'($urandom), POS_W'($urandom));
        for (int i = 0; i < 3; i++)
            send_detection(1'b0, POS_W'($urandom), POS_W'($urandom));
        send_detection(1'b1, 16'sd12, 16'sd34);
        send_detection(1'b0, 16'sd12, 16'sd34);
    endtask

    // random frames under a series of register settings
    task automatic test_random_frames();
        int quota;
        int target;
        quota = 185;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(1'b1, 100, 100);
                1: configure(1'b1, 0, 0);
                2: configure(1'b1, 32767, 32767);
                3: configure(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767));
                4: configure(1'b1, 1, 1);
                5: configure(1'b1, $urandom_range(1, 2000), $urandom_range(1, 2000));
                6: configure(1'b1, $urandom_range(0, 32767), $urandom_range(0, 32767));
                default: begin
                    // closing stretch runs flat out on both sides
                    configure(1'b1, 300, 40);
                    send_gaps   = 1'b0;
                    recv_stalls = 1'b0;
                end
            endcase
            target = detections_sent + quota;
            // one frame that runs past the store size
            if (ph == 4)
                run_frame($urandom_range(MAX_DET + 1, MAX_DET + 6), 1'b1);
            while (detections_sent < target)
                run_frame($urandom_range(1, 24), $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        det_if.valid       <= 1'b0;
        det_if.frame_start <= 1'b0;
        det_if.forward_pos <= '0;
        det_if.lateral_pos <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        i_rst_n            <= 1'b0;
        error_count     = 0;
        detections_sent = 0;
        det_count       = 0;
        clu_count       = 0;
        cfg_merge       = MERGE_RST;
        cfg_lat_acc     = int'(ACC_RST);
        cfg_fwd_acc     = int'(ACC_RST);
        send_gaps       = 1'b1;
        recv_stalls     = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_lowest_cluster();
        test_merge_off();
        test_zero_accept();
        test_wide_accept();
        test_full_store();
        test_random_frames();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS detection_box_clusterer");
        end else begin
            $display("FAIL detection_box_clusterer");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/dbc_pkg.sv
sv/dbc_ifs.sv
sv/dbc_cfg.sv
sv/dbc_cell.sv
sv/detection_box_clusterer.sv
sv/dbc_chk.sv
tb/detection_box_clusterer_tb.sv
